FILE: design/hslrgb_pkg.sv
// shared types, constants and arithmetic helpers for the hsl to rgb converter
package hslrgb_pkg;

   // channel count and lane order on the result word: red, green, blue
   localparam int NUM_CHAN   = 3;
   localparam int CHAN_RED   = 0;
   localparam int CHAN_GREEN = 1;
   localparam int CHAN_BLUE  = 2;

   // default depth of the queue between front and back
   localparam int FIFO_DEPTH = 4;

   // hue thresholds: rising ramp, hold at q, falling ramp, hold at p
   localparam logic [7:0] RISE_END   = 8'd43;
   localparam logic [7:0] HOLD_END   = 8'd128;
   localparam logic [7:0] FALL_END   = 8'd170;
   localparam logic [7:0] RED_OFFS   = 8'd85;
   localparam logic [7:0] BLUE_WRAP  = 8'd170;
   localparam logic [7:0] RED_WRAP   = 8'd171;
   localparam logic [7:0] GAIN_FULL  = 8'd255;
   localparam logic [7:0] GAIN_NONE  = 8'd0;
   localparam logic [9:0] FALL_BASE  = 10'd1020;

   typedef enum logic [1:0] {
      RAMP_UP,
      HOLD_Q,
      RAMP_DOWN,
      HOLD_P
   } region_type;

   typedef logic [7:0] gain_arr_type [NUM_CHAN];

   // one classified pixel: p, q - p and the ramp gain of each channel
   typedef struct packed {
      logic [15:0] pn;
      logic [15:0] dn;
      logic [7:0]  gain_r;
      logic [7:0]  gain_g;
      logic [7:0]  gain_b;
   } work_type;

   // which piece of the ramp a hue position falls in
   function automatic region_type hue_region(input logic [7:0] t);
      region_type rgn;
      if (t < RISE_END) begin
         rgn = RAMP_UP;
      end else if (t < HOLD_END) begin
         rgn = HOLD_Q;
      end else if (t < FALL_END) begin
         rgn = RAMP_DOWN;
      end else begin
         rgn = HOLD_P;
      end
      return rgn;
   endfunction

   // weight of q - p in units of 1/255: 6t, 255, 1020 - 6t or 0
   function automatic logic [7:0] ramp_gain(input logic [7:0] t);
      logic [9:0] t6;
      logic [9:0] fall;
      logic [7:0] gain;
      t6   = ({2'b00, t} << 2) + ({2'b00, t} << 1);
      fall = FALL_BASE - t6;
      unique case (hue_region(t))
         RAMP_UP:   gain = t6[7:0];
         HOLD_Q:    gain = GAIN_FULL;
         RAMP_DOWN: gain = fall[7:0];
         HOLD_P:    gain = GAIN_NONE;
         default:   gain = GAIN_NONE;
      endcase
      return gain;
   endfunction

   // x / 255 estimate via x * 0x01010101 >> 32, low by at most one
   function automatic logic [15:0] div255_est(input logic [23:0] x);
      logic [55:0] xw;
      logic [55:0] prod;
      xw   = {32'd0, x};
      prod = xw + (xw << 8) + (xw << 16) + (xw << 24);
      return prod[47:32];
   endfunction

   // correct the estimate by one when the remainder reaches 255
   function automatic logic [15:0] div255_fix(input logic [23:0] x, input logic [15:0] est);
      logic [23:0] estw;
      logic [23:0] rem;
      estw = {8'd0, est};
      rem  = x - ((estw << 8) - estw);
      return (rem >= 24'd255) ? est + 16'd1 : est;
   endfunction

endpackage

FILE: design/hslrgb_front.sv
// front end: forms p and q, wraps the channel hues and classifies each ramp piece
module hslrgb_front
   import hslrgb_pkg::*;
(
   input  logic [7:0] hue,
   input  logic [7:0] saturation,
   input  logic [7:0] lightness,
   output work_type   work
);

   logic [15:0] ls;
   logic [15:0] l255;
   logic [15:0] s255;
   logic [16:0] qn;
   logic [16:0] l510;
   logic [16:0] pn;
   logic [16:0] dn;
   logic [7:0]  t_red;
   logic [7:0]  t_blue;

   // q in units of 1/65025, split on lightness below one half
   always_comb begin
      ls   = 16'(lightness * saturation);
      l255 = ({8'd0, lightness} << 8) - {8'd0, lightness};
      s255 = ({8'd0, saturation} << 8) - {8'd0, saturation};
      if (!lightness[7]) begin
         qn = {1'b0, l255} + {1'b0, ls};
      end else begin
         qn = {1'b0, l255} + {1'b0, s255} - {1'b0, ls};
      end
      l510 = ({9'd0, lightness} << 9) - ({9'd0, lightness} << 1);
      pn   = l510 - qn;
      dn   = qn - pn;
   end

   // per channel hue position, wrapped into 0..255
   always_comb begin
      t_red  = (hue >= RED_WRAP) ? hue - BLUE_WRAP : hue + RED_OFFS;
      t_blue = (hue < RED_OFFS) ? hue + BLUE_WRAP : hue - RED_OFFS;
   end

   // classified word for the queue
   always_comb begin
      work.pn     = pn[15:0];
      work.dn     = dn[15:0];
      work.gain_r = ramp_gain(t_red);
      work.gain_g = ramp_gain(hue);
      work.gain_b = ramp_gain(t_blue);
   end

endmodule

FILE: design/hslrgb_fifo.sv
// short register queue between the front and back ends
module hslrgb_fifo
   import hslrgb_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  work_type wr_data,
   output logic     rd_valid,
   input  logic     rd_ready,
   output work_type rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push;
   logic               pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/hslrgb_back.sv
// back end: ramp product and exact divide by 65025 in five stages per channel
module hslrgb_back
   import hslrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  work_type    in_work,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [23:0] out_word
);

   logic              adv;
   logic [3:0]        vld_ff;
   logic [3:0]        vld_in;
   logic              out_vld_ff;
   logic              out_vld_in;
   gain_arr_type      gain;
   logic [23:0]       num_ff   [NUM_CHAN];
   logic [23:0]       num_in   [NUM_CHAN];
   logic [23:0]       num2_ff  [NUM_CHAN];
   logic [15:0]       est1_ff  [NUM_CHAN];
   logic [15:0]       est1_in  [NUM_CHAN];
   logic [15:0]       q1_ff    [NUM_CHAN];
   logic [15:0]       q1_in    [NUM_CHAN];
   logic [15:0]       q1b_ff   [NUM_CHAN];
   logic [15:0]       est2_ff  [NUM_CHAN];
   logic [15:0]       est2_in  [NUM_CHAN];
   logic [7:0]        res_ff   [NUM_CHAN];
   logic [7:0]        res_in   [NUM_CHAN];
   logic [15:0]       res_wide [NUM_CHAN];
   logic [23:0]       p255;

   // the whole pipe moves together unless the result is held
   assign adv       = !out_vld_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = out_vld_ff;
   assign out_word  = {res_ff[CHAN_BLUE], res_ff[CHAN_GREEN], res_ff[CHAN_RED]};

   assign gain[CHAN_RED]   = in_work.gain_r;
   assign gain[CHAN_GREEN] = in_work.gain_g;
   assign gain[CHAN_BLUE]  = in_work.gain_b;

   // valid bits
   always_comb begin
      vld_in     = {vld_ff[2:0], in_valid};
      out_vld_in = vld_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // per lane arithmetic: 255p + (q-p)*gain, then two divides by 255
   always_comb begin
      p255 = ({8'd0, in_work.pn} << 8) - {8'd0, in_work.pn};
      for (int c = 0; c < NUM_CHAN; c++) begin
         num_in[c]   = p255 + 24'(in_work.dn * gain[c]);
         est1_in[c]  = div255_est(num_ff[c]);
         q1_in[c]    = div255_fix(num2_ff[c], est1_ff[c]);
         est2_in[c]  = div255_est({8'd0, q1_ff[c]});
         res_wide[c] = div255_fix({8'd0, q1b_ff[c]}, est2_ff[c]);
         res_in[c]   = res_wide[c][7:0];
      end
   end

   // stage payload, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            num_ff[c]  <= num_in[c];
            num2_ff[c] <= num_ff[c];
            est1_ff[c] <= est1_in[c];
            q1_ff[c]   <= q1_in[c];
            q1b_ff[c]  <= q1_ff[c];
            est2_ff[c] <= est2_in[c];
            res_ff[c]  <= res_in[c];
         end
      end
   end

endmodule

FILE: design/hsl_to_rgb_converter.sv
// an accepted input word goes through the queue, then the five registered back stages
// throughput: one pixel per clock unless a held result stalls the five-stage divide pipe
// the FIFO_DEPTH_P word queue takes input while the result is held, until it is full
// reset: synchronous, active high; clears queue pointers and stage valid bits
// no clearing pass; the block accepts words in the first cycle after reset
module hsl_to_rgb_converter
   import hslrgb_pkg::*;
#(
   parameter int FIFO_DEPTH_P = FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // hue[7:0], saturation[15:8], lightness[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   work_type front_work;
   work_type queue_work;
   logic     queue_valid;
   logic     queue_ready;

   // classify the incoming pixel
   hslrgb_front u_front (
      .hue        (req_tdata[7:0]),
      .saturation (req_tdata[15:8]),
      .lightness  (req_tdata[23:16]),
      .work       (front_work)
   );

   // decoupling queue
   hslrgb_fifo #(
      .DEPTH (FIFO_DEPTH_P)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_data  (front_work),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_data  (queue_work)
   );

   // arithmetic pipe and result register
   hslrgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_valid),
      .in_ready  (queue_ready),
      .in_work   (queue_work),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_tdata)
   );

endmodule

FILE: design/hslrgb_checker.sv
// port level checks for the hsl to rgb converter, bound to the top level
module hslrgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic [7:0] pending_ff;
   logic [7:0] pending_in;

   // words accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if ((req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         pending_in = pending_ff + 8'd1;
      end else if (!(req_tvalid && req_tready) && (rsp_tvalid && rsp_tready)) begin
         pending_in = pending_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a held result keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // no result without an outstanding input word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 8'd0)
      else $error("result word with nothing outstanding");

   // an empty block never pushes back on the input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 8'd0 |-> req_tready)
      else $error("input stalled while block empty");

   // reset empties the result side
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind hsl_to_rgb_converter hslrgb_checker u_checker (.*);

FILE: bench/hsl_to_rgb_converter_test.sv
// self-checking bench for the hsl to rgb converter: directed pixels, then random pixels
module hsl_to_rgb_converter_test;

   // ramp limits in hue steps of 1/255, and the unit of p and q (1/255^2)
   localparam int unsigned UNIT_SQ     = 65025;
   localparam int unsigned SIXTH_LIM   = 255;
   localparam int unsigned HALF_LIM    = 255;
   localparam int unsigned TWO3RD_LIM  = 510;
   localparam int unsigned FALL_TOP    = 1020;
   localparam int unsigned HUE_THIRD   = 85;
   localparam int          RANDOM_WORDS = 850;
   localparam int          HOLD_CYCLES  = 60;
   localparam int          DRAIN_CYCLES = 16;
   localparam int          N_DIRECTED   = 22;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rgb_type;

   typedef struct packed {
      logic [7:0]    hue;
      logic [7:0]    sat;
      logic [7:0]    light;
      logic          known;
      pixel_rgb_type rgb;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // hue[7:0], saturation[15:8], lightness[23:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // red[7:0], green[15:8], blue[23:16]

   pixel_rgb_type rgb_pending[$];
   int            mismatches = 0;
   int            words_in   = 0;
   bit            calm       = 1'b0;

   // directed pixels: extremes, ramp edges and hue wrap; known rows where gray or black/white
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{8'd170, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{8'd85,  8'd0,   8'd127, 1'b1, '{8'd127, 8'd127, 8'd127}},
      '{8'd200, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
      '{8'd255, 8'd255, 8'd127, 1'b0, '0},
      '{8'd0,   8'd255, 8'd128, 1'b0, '0},
      '{8'd42,  8'd255, 8'd128, 1'b0, '0},
      '{8'd43,  8'd255, 8'd128, 1'b0, '0},
      '{8'd127, 8'd255, 8'd128, 1'b0, '0},
      '{8'd128, 8'd255, 8'd128, 1'b0, '0},
      '{8'd169, 8'd255, 8'd128, 1'b0, '0},
      '{8'd170, 8'd255, 8'd128, 1'b0, '0},
      '{8'd171, 8'd255, 8'd128, 1'b0, '0},
      '{8'd85,  8'd200, 8'd60,  1'b0, '0},
      '{8'd84,  8'd255, 8'd200, 1'b0, '0},
      '{8'd86,  8'd1,   8'd254, 1'b0, '0},
      '{8'd254, 8'd128, 8'd1,   1'b0, '0},
      '{8'd213, 8'd255, 8'd127, 1'b0, '0},
      '{8'd212, 8'd170, 8'd85,  1'b0, '0},
      '{8'd1,   8'd255, 8'd128, 1'b0, '0}
   };

   // hue positions worth hitting often: ramp edges and wrap points
   logic [7:0] edge_hues [15] = '{8'd0, 8'd42, 8'd43, 8'd84, 8'd85, 8'd86, 8'd127, 8'd128,
                                  8'd169, 8'd170, 8'd171, 8'd212, 8'd213, 8'd254, 8'd255};

   hsl_to_rgb_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, period 8
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one channel level from its hue position and p, q in 1/65025 units
   function automatic logic [7:0] ramp_level(input int unsigned pos, input int unsigned pn,
                                             input int unsigned qn);
      int unsigned span;
      int unsigned level;
      span = qn - pn;
      if (6 * pos < SIXTH_LIM) begin
         level = (255 * pn + span * (6 * pos)) / UNIT_SQ;
      end else if (2 * pos < HALF_LIM) begin
         level = qn / 255;
      end else if (3 * pos < TWO3RD_LIM) begin
         level = (255 * pn + span * (FALL_TOP - 6 * pos)) / UNIT_SQ;
      end else begin
         level = pn / 255;
      end
      return level[7:0];
   endfunction

   // expected rgb of one hsl pixel
   function automatic pixel_rgb_type rgb_from_hsl(input logic [7:0] h, input logic [7:0] s,
                                                  input logic [7:0] l);
      int unsigned   hv;
      int unsigned   sv;
      int unsigned   lv;
      int unsigned   qn;
      int unsigned   pn;
      int unsigned   pos_r;
      int unsigned   pos_b;
      pixel_rgb_type rgb;
      hv = {24'd0, h};
      sv = {24'd0, s};
      lv = {24'd0, l};
      if (2 * lv < 255) begin
         qn = lv * (255 + sv);
      end else begin
         qn = 255 * lv + 255 * sv - lv * sv;
      end
      pn = 510 * lv - qn;
      // red leads by a third, blue lags by a third, both wrapped
      pos_r = hv + HUE_THIRD;
      if (pos_r > 255) begin
         pos_r = pos_r - 255;
      end
      if (hv < HUE_THIRD) begin
         pos_b = hv + 255 - HUE_THIRD;
      end else begin
         pos_b = hv - HUE_THIRD;
      end
      rgb.red   = ramp_level(pos_r, pn, qn);
      rgb.green = ramp_level(hv, pn, qn);
      rgb.blue  = ramp_level(pos_b, pn, qn);
      return rgb;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // offer one pixel word, idling at random first, and log its expected result on accept
   task automatic push_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] l,
                             input pixel_rgb_type rgb);
      while (!calm && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {l, s, h};
      do begin
         @(posedge clock);
      end while (!req_tready);
      rgb_pending.push_back(rgb);
      words_in++;
      @(negedge clock);
   endtask

   // result side: random stalls, one long hold-off to back up the pipe
   initial begin
      int  hold_left;
      bit  held_off;
      hold_left  = 0;
      held_off   = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held_off && words_in >= 150) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 23);
         end
      end
   end

   // compare each result word with the oldest expected pixel
   always @(posedge clock) begin
      pixel_rgb_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rgb_pending.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", rsp_tdata));
         end else begin
            want = rgb_pending.pop_front();
            if (rsp_tdata[7:0] !== want.red) begin
               report_mismatch($sformatf("red %0d, want %0d", rsp_tdata[7:0], want.red));
            end
            if (rsp_tdata[15:8] !== want.green) begin
               report_mismatch($sformatf("green %0d, want %0d", rsp_tdata[15:8], want.green));
            end
            if (rsp_tdata[23:16] !== want.blue) begin
               report_mismatch($sformatf("blue %0d, want %0d", rsp_tdata[23:16], want.blue));
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [7:0] h;
      logic [7:0] s;
      logic [7:0] l;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         push_pixel(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].light,
                    directed_rows[i].known ? directed_rows[i].rgb
                    : rgb_from_hsl(directed_rows[i].hue, directed_rows[i].sat,
                                   directed_rows[i].light));
      end

      // random pixels, some biased to ramp edges, extreme s and l at the one-half split, with a calm stretch
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = (i >= 400 && i < 550);
         h = 8'($urandom_range(255));
         s = 8'($urandom_range(255));
         l = 8'($urandom_range(255));
         if ($urandom_range(99) < 30) begin
            h = edge_hues[4'($urandom_range(14))];
         end
         if ($urandom_range(99) < 10) begin
            s = $urandom_range(1) ? 8'd255 : 8'd0;
         end
         if ($urandom_range(99) < 10) begin
            l = $urandom_range(1) ? 8'd128 : 8'd127;
         end
         push_pixel(h, s, l, rgb_from_hsl(h, s, l));
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      wait (rgb_pending.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && rgb_pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
